// File: rtl/iaa_pkg.sv
// ----------------------------------------------------------------------------
// iaa_pkg
// Opcodes, word layout and multiplier split for the interval arithmetic ALU.
// ----------------------------------------------------------------------------
package iaa_pkg;

    localparam int FIELD_W = 64;
    localparam int S_DATA_W = 392;
    localparam int M_DATA_W = 136;

    // s_tdata field offsets
    localparam int OFF_OP   = 0;
    localparam int OFF_A_LO = 5;
    localparam int OFF_A_HI = 69;
    localparam int OFF_B_LO = 133;
    localparam int OFF_B_HI = 197;
    localparam int OFF_C_LO = 261;
    localparam int OFF_C_HI = 325;

    // multiplier: 32-bit partial products, four register stages
    localparam int PART_W  = 32;
    localparam int MUL_LAT = 4;

    typedef logic [4:0] op_t;

    localparam op_t OP_ADD    = 5'd0;
    localparam op_t OP_SUB    = 5'd1;
    localparam op_t OP_MUL    = 5'd2;
    localparam op_t OP_DIV    = 5'd3;
    localparam op_t OP_MOD    = 5'd4;
    localparam op_t OP_NEG    = 5'd5;
    localparam op_t OP_AND    = 5'd6;
    localparam op_t OP_OR     = 5'd7;
    localparam op_t OP_XOR    = 5'd8;
    localparam op_t OP_NOT    = 5'd9;
    localparam op_t OP_SHL    = 5'd10;
    localparam op_t OP_LSHR   = 5'd11;
    localparam op_t OP_ASHR   = 5'd12;
    localparam op_t OP_EQ     = 5'd13;
    localparam op_t OP_NE     = 5'd14;
    localparam op_t OP_LT     = 5'd15;
    localparam op_t OP_LE     = 5'd16;
    localparam op_t OP_GT     = 5'd17;
    localparam op_t OP_GE     = 5'd18;
    localparam op_t OP_LNOT   = 5'd19;
    localparam op_t OP_LAND   = 5'd20;
    localparam op_t OP_LOR    = 5'd21;
    localparam op_t OP_JOIN   = 5'd22;
    localparam op_t OP_MEET   = 5'd23;
    localparam op_t OP_SELECT = 5'd24;

endpackage

// File: rtl/interval_arithmetic_alu.sv
// ----------------------------------------------------------------------------
// interval_arithmetic_alu
// Throughput: one word per cycle while the output is not stalled; the depth is set by the bit-per-stage divider.
// The whole pipeline advances together; it holds when m_tvalid is high and
// m_tready is low, and s_tready drops with it.
// Reset (aresetn low, synchronous) clears all valid bits; data is not reset.
// ----------------------------------------------------------------------------
module interval_arithmetic_alu
    import iaa_pkg::*;
#(
    parameter int BOUND_WIDTH = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // op, a_low, a_high, b_low, b_high, c_low, c_high
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // res_low, res_high, cmp_true
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int W   = BOUND_WIDTH;
    localparam int LD  = W + 2;
    localparam int MD  = LD - MUL_LAT;
    localparam int SHW = $clog2(W);
    localparam logic signed [W-1:0] INF    = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] NINF   = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] ZERO   = '0;
    localparam logic signed [W-1:0] ONE    = W'(1);
    localparam logic signed [W-1:0] NEG1   = '1;
    localparam logic signed [W-1:0] SH_MAX = W'(W - 1);

    typedef enum logic [1:0] {K_SIMPLE, K_MUL, K_DIV, K_MODC} kind_t;

    typedef struct packed {
        logic                valid;
        op_t                 op;
        kind_t               kind;
        logic signed [W-1:0] lo;
        logic signed [W-1:0] hi;
        logic                cmp;
    } item_t;

    logic m_valid_reg;
    logic en;
    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    // ---------------- stage 1: capture ----------------
    logic                s1_valid_reg;
    op_t                 s1_op_reg;
    logic signed [W-1:0] a_lo_reg, a_hi_reg, b_lo_reg, b_hi_reg, c_lo_reg, c_hi_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= s_tvalid;
        end
        if (en) begin
            s1_op_reg <= s_tdata[OFF_OP +: 5];
            a_lo_reg  <= s_tdata[OFF_A_LO +: W];
            a_hi_reg  <= s_tdata[OFF_A_HI +: W];
            b_lo_reg  <= s_tdata[OFF_B_LO +: W];
            b_hi_reg  <= s_tdata[OFF_B_HI +: W];
            c_lo_reg  <= s_tdata[OFF_C_LO +: W];
            c_hi_reg  <= s_tdata[OFF_C_HI +: W];
        end
    end

    // ---------------- corner units ----------------
    logic signed [W-1:0] mul_p [0:3];
    logic signed [W-1:0] div_q [0:3];
    logic signed [W-1:0] div_r [0:3];
    logic signed [W-1:0] cx    [0:3];
    logic signed [W-1:0] cy    [0:3];

    always_comb begin
        cx[0] = a_lo_reg; cy[0] = b_lo_reg;
        cx[1] = a_lo_reg; cy[1] = b_hi_reg;
        cx[2] = a_hi_reg; cy[2] = b_lo_reg;
        cx[3] = a_hi_reg; cy[3] = b_hi_reg;
    end

    for (genvar i = 0; i < 4; i++) begin : g_lane
        iaa_mul #(.W(W)) u_mul (
            .aclk(aclk), .en(en), .x(cx[i]), .y(cy[i]), .p(mul_p[i])
        );
        iaa_div #(.W(W)) u_div (
            .aclk(aclk), .en(en), .x(cx[i]), .y(cy[i]), .q(div_q[i]), .r(div_r[i])
        );
    end

    // ---------------- helpers ----------------
    function automatic logic signed [W-1:0] sat_fit(input logic [W:0] v);
        if (v[W] != v[W-1]) return v[W] ? NINF : INF;
        return v[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] sat_neg(input logic signed [W-1:0] x);
        return (x == NINF) ? INF : -x;
    endfunction

    function automatic logic signed [W-1:0] smin(input logic signed [W-1:0] x,
                                                 input logic signed [W-1:0] y);
        return (x < y) ? x : y;
    endfunction

    function automatic logic signed [W-1:0] smax(input logic signed [W-1:0] x,
                                                 input logic signed [W-1:0] y);
        return (x > y) ? x : y;
    endfunction

    function automatic logic signed [W-1:0] mag_m1(input logic signed [W-1:0] x);
        logic [W-1:0] m;
        m = x[W-1] ? (W'(0) - x) : x;
        return m - W'(1);
    endfunction

    // all ones up to the top set bit
    function automatic logic signed [W-1:0] cover_ones(input logic signed [W-1:0] m);
        logic [W-1:0] r;
        for (int i = 0; i < W; i++) r[i] = |(m >> i);
        return r;
    endfunction

    function automatic logic signed [W-1:0] shl_sat(input logic signed [W-1:0] x,
                                                    input logic [SHW-1:0] s);
        logic signed [W-1:0] t;
        t = x <<< s;
        if ((t >>> s) != x) return x[W-1] ? NINF : INF;
        return t;
    endfunction

    // ---------------- stage 2: non-corner ops ----------------
    item_t s2_next;
    logic  emp_a, emp_b, emp_any, top_a, top_b, con_a, con_b, span_b;
    logic signed [W-1:0] t_lo, t_hi, c1, sh_l, sh_u;
    logic [SHW-1:0] amt_l, amt_u;

    always_comb begin
        emp_a   = a_lo_reg > a_hi_reg;
        emp_b   = b_lo_reg > b_hi_reg;
        emp_any = emp_a || emp_b;
        top_a   = (a_lo_reg == NINF) && (a_hi_reg == INF);
        top_b   = (b_lo_reg == NINF) && (b_hi_reg == INF);
        con_a   = a_lo_reg == a_hi_reg;
        con_b   = b_lo_reg == b_hi_reg;
        span_b  = (b_lo_reg <= ZERO) && (b_hi_reg >= ZERO);
        c1      = con_b ? mag_m1(b_lo_reg)
                        : smax(mag_m1(b_lo_reg), mag_m1(b_hi_reg));
        sh_l    = (a_lo_reg >= ZERO) ? b_lo_reg : b_hi_reg;
        sh_u    = (a_hi_reg >= ZERO) ? b_hi_reg : b_lo_reg;
        amt_l   = (b_lo_reg > SH_MAX) ? SHW'(SH_MAX) : b_lo_reg[SHW-1:0];
        amt_u   = (b_hi_reg > SH_MAX) ? SHW'(SH_MAX) : b_hi_reg[SHW-1:0];
        t_lo    = emp_b ? c_lo_reg : smin(b_lo_reg, c_lo_reg);
        t_hi    = emp_b ? c_hi_reg : smax(b_hi_reg, c_hi_reg);

        s2_next       = '0;
        s2_next.valid = s1_valid_reg;
        s2_next.op    = s1_op_reg;
        s2_next.kind  = K_SIMPLE;

        if (s1_op_reg <= OP_ASHR && s1_op_reg != OP_NEG && s1_op_reg != OP_NOT && emp_any) begin
            s2_next.lo = INF; s2_next.hi = NINF;
        end else if ((s1_op_reg == OP_NEG || s1_op_reg == OP_NOT) && emp_a) begin
            s2_next.lo = INF; s2_next.hi = NINF;
        end else begin
            case (s1_op_reg)
                OP_ADD: begin
                    s2_next.lo = sat_fit({a_lo_reg[W-1], a_lo_reg} + {b_lo_reg[W-1], b_lo_reg});
                    s2_next.hi = sat_fit({a_hi_reg[W-1], a_hi_reg} + {b_hi_reg[W-1], b_hi_reg});
                end
                OP_SUB: begin
                    s2_next.lo = sat_fit({a_lo_reg[W-1], a_lo_reg} - {b_hi_reg[W-1], b_hi_reg});
                    s2_next.hi = sat_fit({a_hi_reg[W-1], a_hi_reg} - {b_lo_reg[W-1], b_lo_reg});
                end
                OP_MUL: s2_next.kind = K_MUL;
                OP_DIV: begin
                    if (span_b) begin
                        s2_next.lo = NINF; s2_next.hi = INF;
                    end else begin
                        s2_next.kind = K_DIV;
                    end
                end
                OP_MOD: begin
                    if (span_b) begin
                        s2_next.lo = NINF; s2_next.hi = INF;
                    end else if (con_a && con_b) begin
                        if (b_lo_reg != NEG1) s2_next.kind = K_MODC;
                    end else if (con_b && a_lo_reg >= ZERO) begin
                        s2_next.hi = smin(a_hi_reg, c1);
                    end else begin
                        s2_next.lo = -c1; s2_next.hi = c1;
                    end
                end
                OP_NEG: begin
                    s2_next.lo = sat_neg(a_hi_reg); s2_next.hi = sat_neg(a_lo_reg);
                end
                OP_AND: begin
                    if (con_a && con_b) begin
                        s2_next.lo = a_lo_reg & b_lo_reg; s2_next.hi = a_lo_reg & b_lo_reg;
                    end else if (a_lo_reg >= ZERO && b_lo_reg >= ZERO) begin
                        s2_next.hi = smin(a_hi_reg, b_hi_reg);
                    end else if (a_lo_reg >= ZERO) begin
                        s2_next.hi = a_hi_reg;
                    end else if (b_lo_reg >= ZERO) begin
                        s2_next.hi = b_hi_reg;
                    end else begin
                        s2_next.lo = NINF; s2_next.hi = INF;
                    end
                end
                OP_OR: begin
                    if (con_a && con_b) begin
                        s2_next.lo = a_lo_reg | b_lo_reg; s2_next.hi = a_lo_reg | b_lo_reg;
                    end else if (a_lo_reg >= ZERO && b_lo_reg >= ZERO) begin
                        s2_next.lo = smax(a_lo_reg, b_lo_reg);
                        s2_next.hi = cover_ones(smax(a_hi_reg, b_hi_reg));
                    end else begin
                        s2_next.lo = NINF; s2_next.hi = INF;
                    end
                end
                OP_XOR: begin
                    if (con_a && con_b) begin
                        s2_next.lo = a_lo_reg ^ b_lo_reg; s2_next.hi = a_lo_reg ^ b_lo_reg;
                    end else if (a_lo_reg >= ZERO && b_lo_reg >= ZERO) begin
                        s2_next.hi = cover_ones(smax(a_hi_reg, b_hi_reg));
                    end else begin
                        s2_next.lo = NINF; s2_next.hi = INF;
                    end
                end
                OP_NOT: begin
                    s2_next.lo = NINF; s2_next.hi = INF;
                end
                OP_SHL: begin
                    if (b_lo_reg < ZERO || b_hi_reg >= SH_MAX) begin
                        s2_next.lo = NINF; s2_next.hi = INF;
                    end else begin
                        s2_next.lo = shl_sat(a_lo_reg, sh_l[SHW-1:0]);
                        s2_next.hi = shl_sat(a_hi_reg, sh_u[SHW-1:0]);
                    end
                end
                OP_LSHR, OP_ASHR: begin
                    if (b_lo_reg < ZERO || (s1_op_reg == OP_LSHR && a_lo_reg < ZERO)) begin
                        s2_next.lo = NINF; s2_next.hi = INF;
                    end else begin
                        s2_next.lo = a_lo_reg >>> amt_u;
                        s2_next.hi = a_hi_reg >>> amt_l;
                    end
                end
                OP_EQ, OP_NE: begin
                    s2_next.cmp = (emp_a && emp_b) || (top_a && top_b)
                               || (a_lo_reg == b_lo_reg && a_hi_reg == b_hi_reg);
                    if (s1_op_reg == OP_NE) s2_next.cmp = !s2_next.cmp;
                end
                OP_LT: s2_next.cmp = !(emp_a && emp_b) && !(top_a && top_b)
                                  && a_lo_reg > b_lo_reg && a_hi_reg < b_hi_reg;
                OP_GT: s2_next.cmp = !(emp_a && emp_b) && !(top_a && top_b)
                                  && b_lo_reg > a_lo_reg && b_hi_reg < a_hi_reg;
                OP_LE: s2_next.cmp = (emp_a && emp_b) || (top_a && top_b)
                                  || (a_lo_reg >= b_lo_reg && a_hi_reg <= b_hi_reg);
                OP_GE: s2_next.cmp = (emp_a && emp_b) || (top_a && top_b)
                                  || (b_lo_reg >= a_lo_reg && b_hi_reg <= a_hi_reg);
                OP_LNOT: begin
                    // true unless the interval excludes zero
                    if (a_lo_reg > ZERO || a_hi_reg < ZERO) begin
                        s2_next.lo = ZERO; s2_next.hi = ZERO;
                    end else begin
                        s2_next.lo = ONE; s2_next.hi = ONE;
                    end
                end
                OP_LAND: begin
                    s2_next.lo = (a_lo_reg != ZERO && b_lo_reg != ZERO) ? ONE : ZERO;
                    s2_next.hi = ONE;
                end
                OP_LOR: begin
                    s2_next.lo = (a_lo_reg != ZERO || b_lo_reg != ZERO) ? ONE : ZERO;
                    s2_next.hi = ONE;
                end
                OP_JOIN: begin
                    if (emp_a) begin
                        s2_next.lo = b_lo_reg; s2_next.hi = b_hi_reg;
                    end else if (emp_b) begin
                        s2_next.lo = a_lo_reg; s2_next.hi = a_hi_reg;
                    end else begin
                        s2_next.lo = smin(a_lo_reg, b_lo_reg);
                        s2_next.hi = smax(a_hi_reg, b_hi_reg);
                    end
                end
                OP_MEET: begin
                    if (emp_any) begin
                        s2_next.lo = INF; s2_next.hi = NINF;
                    end else begin
                        s2_next.lo = smax(a_lo_reg, b_lo_reg);
                        s2_next.hi = smin(a_hi_reg, b_hi_reg);
                    end
                end
                OP_SELECT: begin
                    if (a_lo_reg == ONE && a_hi_reg == ONE) begin
                        s2_next.lo = b_lo_reg; s2_next.hi = b_hi_reg;
                    end else if (a_lo_reg == ZERO && a_hi_reg == ZERO) begin
                        s2_next.lo = c_lo_reg; s2_next.hi = c_hi_reg;
                    end else if (!emp_b && c_lo_reg > c_hi_reg) begin
                        s2_next.lo = b_lo_reg; s2_next.hi = b_hi_reg;
                    end else begin
                        // join of b and c, b possibly empty
                        s2_next.lo = t_lo; s2_next.hi = t_hi;
                    end
                end
                default: ;
            endcase
        end
    end

    // ---------------- alignment lines ----------------
    item_t               dly_reg  [0:LD-1];
    item_t               dly_next [0:LD-1];
    logic signed [W-1:0] mdly_reg [0:3][0:MD-1];

    always_comb begin
        dly_next[0] = en ? s2_next : dly_reg[0];
        for (int k = 1; k < LD; k++) dly_next[k] = en ? dly_reg[k-1] : dly_reg[k];
        if (!aresetn) begin
            for (int k = 0; k < LD; k++) dly_next[k].valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < LD; k++) dly_reg[k] <= dly_next[k];
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                mdly_reg[i][0] <= mul_p[i];
                for (int k = 1; k < MD; k++) mdly_reg[i][k] <= mdly_reg[i][k-1];
            end
        end
    end

    // ---------------- output stage ----------------
    item_t               dv;
    logic signed [W-1:0] v0, v1, v2, v3, lo_next, hi_next;
    logic                m_cmp_reg;
    op_t                 m_op_reg;
    logic signed [W-1:0] m_lo_reg, m_hi_reg;

    always_comb begin
        dv = dly_reg[LD-1];
        if (dv.kind == K_MUL) begin
            v0 = mdly_reg[0][MD-1]; v1 = mdly_reg[1][MD-1];
            v2 = mdly_reg[2][MD-1]; v3 = mdly_reg[3][MD-1];
        end else begin
            v0 = div_q[0]; v1 = div_q[1]; v2 = div_q[2]; v3 = div_q[3];
        end
        case (dv.kind)
            K_MUL, K_DIV: begin
                lo_next = smin(smin(v0, v1), smin(v2, v3));
                hi_next = smax(smax(v0, v1), smax(v2, v3));
            end
            K_MODC: begin
                lo_next = div_r[0]; hi_next = div_r[0];
            end
            default: begin
                lo_next = dv.lo; hi_next = dv.hi;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dv.valid;
        end
        if (en) begin
            m_lo_reg  <= lo_next;
            m_hi_reg  <= hi_next;
            m_cmp_reg <= dv.cmp;
            m_op_reg  <= dv.op;
        end
    end

    logic signed [FIELD_W-1:0] res_low, res_high;
    assign res_low  = FIELD_W'(m_lo_reg);
    assign res_high = FIELD_W'(m_hi_reg);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, m_cmp_reg, res_high, res_low};

    // ---------------- assertions ----------------
    a_cmp_only_compare: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_cmp_reg |-> (m_op_reg >= OP_EQ && m_op_reg <= OP_GE))
        else $error("compare flag on a non-compare word");

    a_cmp_zero_interval: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_op_reg >= OP_EQ && m_op_reg <= OP_GE
        |-> (m_lo_reg == ZERO && m_hi_reg == ZERO))
        else $error("compare word with nonzero interval");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid_reg)
        else $error("output valid after reset");

endmodule

// File: rtl/iaa_mul.sv
// ----------------------------------------------------------------------------
// iaa_mul
// Saturating signed multiplier, four stages: magnitude, partial products,
// sum, clamp.
// ----------------------------------------------------------------------------
module iaa_mul
    import iaa_pkg::*;
#(
    parameter int W = 64
) (
    input  logic                aclk,
    input  logic                en,
    input  logic signed [W-1:0] x,
    input  logic signed [W-1:0] y,
    output logic signed [W-1:0] p
);

    localparam int PW = 2 * PART_W;
    localparam int SW = 4 * PART_W;
    localparam logic [SW-1:0] LIM_POS = (SW'(1) << (W - 1)) - SW'(1);
    localparam logic [SW-1:0] LIM_NEG = SW'(1) << (W - 1);
    localparam logic signed [W-1:0] INF  = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] NINF = {1'b1, {(W-1){1'b0}}};

    logic [PW-1:0] ma_reg, mb_reg, ma_next, mb_next;
    logic          neg_a_reg, neg_b_reg, neg_c_reg;
    logic [PW-1:0] ll_reg, lh_reg, hl_reg, hh_reg;
    logic [SW-1:0] prod_reg, prod_next;
    logic signed [W-1:0] p_reg, p_next;

    always_comb begin
        ma_next = PW'(x[W-1] ? (W'(0) - x) : x);
        mb_next = PW'(y[W-1] ? (W'(0) - y) : y);
    end

    always_comb begin
        prod_next = SW'(ll_reg) + (SW'(lh_reg) << PART_W) + (SW'(hl_reg) << PART_W)
                  + (SW'(hh_reg) << PW);
    end

    always_comb begin
        if (prod_reg > (neg_c_reg ? LIM_NEG : LIM_POS)) begin
            p_next = neg_c_reg ? NINF : INF;
        end else if (neg_c_reg) begin
            p_next = W'(0) - prod_reg[W-1:0];
        end else begin
            p_next = prod_reg[W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ma_reg    <= ma_next;
            mb_reg    <= mb_next;
            neg_a_reg <= x[W-1] ^ y[W-1];
            ll_reg    <= ma_reg[PART_W-1:0] * mb_reg[PART_W-1:0];
            lh_reg    <= ma_reg[PART_W-1:0] * mb_reg[PW-1:PART_W];
            hl_reg    <= ma_reg[PW-1:PART_W] * mb_reg[PART_W-1:0];
            hh_reg    <= ma_reg[PW-1:PART_W] * mb_reg[PW-1:PART_W];
            neg_b_reg <= neg_a_reg;
            prod_reg  <= prod_next;
            neg_c_reg <= neg_b_reg;
            p_reg     <= p_next;
        end
    end

    assign p = p_reg;

endmodule

// File: rtl/iaa_div.sv
// ----------------------------------------------------------------------------
// iaa_div
// Pipelined signed divider, one quotient bit per stage, truncating quotient
// and remainder; a positive quotient of 2^(W-1) saturates.
// ----------------------------------------------------------------------------
module iaa_div
    import iaa_pkg::*;
#(
    parameter int W = 64
) (
    input  logic                aclk,
    input  logic                en,
    input  logic signed [W-1:0] x,
    input  logic signed [W-1:0] y,
    output logic signed [W-1:0] q,
    output logic signed [W-1:0] r
);

    localparam logic signed [W-1:0] INF = {1'b0, {(W-1){1'b1}}};

    logic [W-1:0] n_reg   [0:W];
    logic [W-1:0] rem_reg [0:W];
    logic [W-1:0] d_reg   [0:W];
    logic         qn_reg  [0:W];
    logic         rn_reg  [0:W];
    logic signed [W-1:0] q_reg, r_reg, q_next, r_next;

    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg[0]   <= x[W-1] ? (W'(0) - x) : x;
            d_reg[0]   <= y[W-1] ? (W'(0) - y) : y;
            rem_reg[0] <= '0;
            qn_reg[0]  <= x[W-1] ^ y[W-1];
            rn_reg[0]  <= x[W-1];
        end
    end

    for (genvar k = 1; k <= W; k++) begin : g_stage
        logic [W:0]   part_next;
        logic         ge_next;
        logic [W-1:0] rem_next;

        always_comb begin
            part_next = {rem_reg[k-1], n_reg[k-1][W-1]};
            ge_next   = part_next >= {1'b0, d_reg[k-1]};
            rem_next  = ge_next ? W'(part_next - {1'b0, d_reg[k-1]}) : part_next[W-1:0];
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                n_reg[k]   <= {n_reg[k-1][W-2:0], ge_next};
                rem_reg[k] <= rem_next;
                d_reg[k]   <= d_reg[k-1];
                qn_reg[k]  <= qn_reg[k-1];
                rn_reg[k]  <= rn_reg[k-1];
            end
        end
    end

    always_comb begin
        if (qn_reg[W]) begin
            q_next = W'(0) - n_reg[W];
        end else begin
            q_next = n_reg[W][W-1] ? INF : n_reg[W];
        end
        r_next = rn_reg[W] ? (W'(0) - rem_reg[W]) : rem_reg[W];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign q = q_reg;
    assign r = r_reg;

endmodule
